[rtl/fdep_pkg.sv]
// shared types and constants of the fat directory entry parser
package fdep_pkg;

  localparam int unsigned LongNameSlots = 4;
  localparam int unsigned CountLimit    = 65535;
  localparam int unsigned CharsPerSlot  = 13;
  localparam int unsigned MaxResults    = 64;
  localparam int unsigned LongCap       = MaxResults - 12;

  typedef enum logic [1:0] {
    KIND_LONG  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_BARE  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  // entry byte offset of long-name character i
  function automatic logic [4:0] lfn_offset(input logic [3:0] i);
    logic [4:0] r;
    begin
      case (i)
        4'd0:  r = 5'd1;
        4'd1:  r = 5'd3;
        4'd2:  r = 5'd5;
        4'd3:  r = 5'd7;
        4'd4:  r = 5'd9;
        4'd5:  r = 5'd14;
        4'd6:  r = 5'd16;
        4'd7:  r = 5'd18;
        4'd8:  r = 5'd20;
        4'd9:  r = 5'd22;
        4'd10: r = 5'd24;
        4'd11: r = 5'd28;
        4'd12: r = 5'd30;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

  // result item sent to the output stage
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
    logic [15:0] entry_index;
    logic [7:0]  attributes;
    logic [15:0] record_count;
    logic        last;
  } result_t;

endpackage

[rtl/fdep_out_reg.sv]
// output register stage for result transfers
module fdep_out_reg
  import fdep_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q;
  result_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // hold one result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

[rtl/fat_directory_entry_parser_core.sv]
// Directory bytes are taken one per transfer on s_axis, and nothing more is
// taken while an entry is being turned into results or an end result waits
// in ST_END. The 32nd byte starts a sequencer that walks the entry one step
// per cycle, unless m_axis stalls it, through a single shared byte reader
// and compare unit, storing a long-name slot one character per step. A
// record is classified first, then each stored long-name character is read
// from the name store through a register (ST_LREAD) and emitted (ST_LONG),
// each long-name slot takes one more ST_LREAD step, and 11 steps go over the
// 8.3 name plus one for the dot, emitting at most one result per cycle
// through a one-entry output register. The input is held for the whole
// record, m_axis stalls included. m_axis_tdata packs from bit 0: kind(2)
// name_char(8) first_cluster(32) file_size(32) entry_index(16)
// attributes(8) record_count(16), padded to 120 bits; tlast marks the final
// result.
module fat_directory_entry_parser_core
  import fdep_pkg::*;
#(
  parameter int unsigned LONG_NAME_SLOTS = LongNameSlots,
  parameter int unsigned COUNT_LIMIT     = CountLimit
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // dir_byte
  input  logic         s_axis_tuser,   // first_of_directory
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // kind, name_char, first_cluster, file_size,
                                       // entry_index, attributes, record_count
  output logic         m_axis_tlast    // last
);

  localparam int unsigned NameDepth = LONG_NAME_SLOTS * CharsPerSlot;
  localparam int unsigned NameAw    = $clog2(NameDepth);
  localparam int unsigned SlotW     = (LONG_NAME_SLOTS > 1) ? $clog2(LONG_NAME_SLOTS) : 1;
  localparam logic [15:0] Limit     = 16'(COUNT_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_END,
    ST_LFN,
    ST_LREAD,
    ST_LONG,
    ST_SHORT,
    ST_BARE
  } state_e;

  state_e state_q;
  logic [7:0]  entry_q [32];
  logic [7:0]  names_q [NameDepth];
  logic [7:0]  name_rd_q;
  logic [3:0]  len_q [LONG_NAME_SLOTS];
  logic [4:0]  pos_q;
  logic [15:0] ecount_q, rcount_q, idx_q;
  logic        ended_q;
  logic [SlotW-1:0] slot_q;
  logic [3:0]  step_q;
  logic [5:0]  nout_q;
  logic [5:0]  long_total_q;
  logic        stopped_q;
  logic [31:0] clus_q, size_q;

  // output stage
  result_t res;
  logic    res_valid, res_ready;
  result_t out_res;

  fdep_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_ready_o (res_ready),
    .in_data_i  (res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.record_count, out_res.attributes,
                         out_res.entry_index, out_res.file_size,
                         out_res.first_cluster, out_res.name_char, out_res.kind};
  assign m_axis_tlast = out_res.last;

  assign s_axis_tready = (state_q == ST_IDLE);
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // effective state after a directory start
  logic [4:0]  pos_eff;
  logic        ended_eff;
  logic [15:0] ecount_eff, rcount_eff;
  assign pos_eff    = s_axis_tuser ? 5'd0  : pos_q;
  assign ended_eff  = s_axis_tuser ? 1'b0  : ended_q;
  assign ecount_eff = s_axis_tuser ? 16'd0 : ecount_q;
  assign rcount_eff = s_axis_tuser ? 16'd0 : rcount_q;

  // shared byte reader and classifier
  logic [7:0] e0, attr, lfn_byte, sc, sc_low;
  logic [4:0] sidx;
  assign e0   = entry_q[0];
  assign attr = entry_q[11];
  assign lfn_byte = entry_q[lfn_offset(step_q)];
  assign sidx = 5'(step_q);
  always_comb begin
    sc = entry_q[sidx];
    if (step_q == 4'd0 && sc == 8'h05) sc = 8'he5;
    sc_low = (sc >= 8'h41 && sc <= 8'h5a) ? sc + 8'd32 : sc;
  end

  // long-name read position
  logic [3:0] cur_len;
  logic [NameAw-1:0] rd_addr;
  assign cur_len = (len_q[slot_q] > 4'd13) ? 4'd13 : len_q[slot_q];
  assign rd_addr = NameAw'(slot_q) * NameAw'(CharsPerSlot) + NameAw'(step_q);

  // stored long-name length over all slots, capped per record
  logic [8:0] len_sum;
  logic [5:0] long_total;
  always_comb begin
    len_sum = '0;
    for (int s = 0; s < LONG_NAME_SLOTS; s++) len_sum = len_sum + 9'(len_q[s]);
    long_total = (len_sum > 9'(LongCap)) ? 6'(LongCap) : len_sum[5:0];
  end

  // 8.3 name made of spaces only
  logic short_empty;
  always_comb begin
    short_empty = 1'b1;
    for (int j = 0; j < 11; j++) begin
      if (entry_q[j] != 8'h20) short_empty = 1'b0;
    end
  end

  logic [15:0] rc_inc;
  assign rc_inc = (rcount_q >= Limit) ? Limit : rcount_q + 16'd1;

  logic [3:0] seq;
  assign seq = e0[3:0];

  // long-name character store enable
  logic lfn_wr;
  assign lfn_wr = (state_q == ST_LFN) && !stopped_q && (e0 != 8'he5) &&
                  ((attr & 8'h3f) == 8'h0f) && (seq != 4'd0) &&
                  (32'(seq) <= LONG_NAME_SLOTS) &&
                  (lfn_byte != 8'h00) && (lfn_byte != 8'hff);

  // result build
  logic dot_pend_q;
  always_comb begin
    res = '0;
    res_valid = 1'b0;
    res.first_cluster = clus_q;
    res.file_size     = size_q;
    res.entry_index   = idx_q;
    res.attributes    = attr;
    res.record_count  = rcount_q;
    case (state_q)
      ST_END: begin
        res_valid = 1'b1;
        res.kind = KIND_END;
        res.first_cluster = '0;
        res.file_size = '0;
        res.attributes = '0;
        res.last = 1'b1;
      end
      ST_LONG: begin
        res_valid = 1'b1;
        res.kind = KIND_LONG;
        res.name_char = name_rd_q;
        // final long-name character ends the record when no 8.3 name follows
        res.last = short_empty && (nout_q + 6'd1 == long_total_q);
      end
      ST_SHORT: begin
        if (sc != 8'h20) begin
          res_valid = 1'b1;
          res.kind = KIND_SHORT;
          res.name_char = (step_q == 4'd8 && !dot_pend_q) ? 8'h2e : sc_low;
          // last when no later non-space byte remains
          res.last = 1'b1;
          for (int j = 0; j < 11; j++) begin
            if (4'(j) > step_q && entry_q[j] != 8'h20) res.last = 1'b0;
          end
          if (step_q == 4'd8 && !dot_pend_q) res.last = 1'b0;
        end
      end
      ST_BARE: begin
        res_valid = 1'b1;
        res.kind = KIND_BARE;
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  logic fire;
  assign fire = res_valid && res_ready;

  // entry memory and long-name store
  always_ff @(posedge clk_i) begin
    if (acc && !ended_eff && !(pos_eff == 5'd0 && s_axis_tdata == 8'd0)) begin
      entry_q[pos_eff] <= s_axis_tdata;
    end
    if (lfn_wr) begin
      names_q[NameAw'(seq - 4'd1) * NameAw'(CharsPerSlot) + NameAw'(step_q)] <= lfn_byte;
    end
    if (state_q == ST_LREAD) begin
      name_rd_q <= names_q[rd_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0;
      ecount_q <= '0;
      rcount_q <= '0;
      ended_q <= 1'b0;
      idx_q <= '0;
      slot_q <= '0;
      step_q <= '0;
      nout_q <= '0;
      long_total_q <= '0;
      stopped_q <= 1'b0;
      dot_pend_q <= 1'b0;
      clus_q <= '0;
      size_q <= '0;
      for (int s = 0; s < LONG_NAME_SLOTS; s++) len_q[s] <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            if (s_axis_tuser) begin
              for (int s = 0; s < LONG_NAME_SLOTS; s++) len_q[s] <= '0;
            end
            pos_q <= pos_eff;
            ecount_q <= ecount_eff;
            rcount_q <= rcount_eff;
            ended_q <= ended_eff;
            if (!ended_eff) begin
              if (pos_eff == 5'd0 && s_axis_tdata == 8'd0) begin
                ended_q <= 1'b1;
                idx_q <= ecount_eff;
                state_q <= ST_END;
              end else if (pos_eff != 5'd31) begin
                pos_q <= pos_eff + 5'd1;
              end else begin
                pos_q <= '0;
                idx_q <= ecount_eff;
                ecount_q <= (ecount_eff >= Limit) ? Limit : ecount_eff + 16'd1;
                state_q <= ST_LFN;
                step_q <= '0;
                stopped_q <= 1'b0;
                // classification is done in ST_LFN once byte 31 is stored
              end
            end
          end
        end
        ST_END: begin
          if (fire) state_q <= ST_IDLE;
        end
        ST_LFN: begin
          // first cycle of an entry: classify, then walk long-name bytes
          if (step_q == 4'd0 && !stopped_q && (e0 == 8'he5)) begin
            state_q <= ST_IDLE;
          end else if ((attr & 8'h3f) == 8'h0f) begin
            if (seq == 4'd0 || 32'(seq) > LONG_NAME_SLOTS) begin
              state_q <= ST_IDLE;
            end else if (stopped_q || lfn_byte == 8'h00 || lfn_byte == 8'hff) begin
              len_q[SlotW'(seq - 4'd1)] <= step_q;
              state_q <= ST_IDLE;
            end else if (step_q == 4'd12) begin
              len_q[SlotW'(seq - 4'd1)] <= 4'd13;
              state_q <= ST_IDLE;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end else if ((attr & 8'h18) == 8'h08 &&
                       (entry_q[20] | entry_q[21] | entry_q[26] | entry_q[27]) != 8'd0) begin
            state_q <= ST_IDLE;
          end else begin
            size_q <= {entry_q[31], entry_q[30], entry_q[29], entry_q[28]};
            clus_q <= ({entry_q[31], entry_q[30], entry_q[29], entry_q[28]} == 32'd0) ?
                      32'd0 : {entry_q[21], entry_q[20], entry_q[27], entry_q[26]};
            rcount_q <= rc_inc;
            slot_q <= '0;
            step_q <= '0;
            nout_q <= '0;
            long_total_q <= long_total;
            dot_pend_q <= 1'b0;
            state_q <= ST_LREAD;
          end
        end
        ST_LREAD: begin
          // fetch the next stored character or move on to the next slot
          if (step_q < cur_len && nout_q < 6'(LongCap)) begin
            state_q <= ST_LONG;
          end else if (32'(slot_q) == LONG_NAME_SLOTS - 1) begin
            step_q <= '0;
            state_q <= ST_SHORT;
          end else begin
            slot_q <= slot_q + SlotW'(1);
            step_q <= '0;
          end
        end
        ST_LONG: begin
          if (fire) begin
            nout_q <= nout_q + 6'd1;
            step_q <= step_q + 4'd1;
            state_q <= ST_LREAD;
          end
        end
        ST_SHORT: begin
          if (sc == 8'h20 || fire) begin
            if (sc != 8'h20 && step_q == 4'd8 && !dot_pend_q) begin
              dot_pend_q <= 1'b1;
            end else if (sc != 8'h20 && res.last) begin
              for (int s = 0; s < LONG_NAME_SLOTS; s++) len_q[s] <= '0;
              state_q <= ST_IDLE;
            end else if (step_q == 4'd10) begin
              // nothing emitted at all, neither long nor short name
              if (nout_q == 6'd0) begin
                state_q <= ST_BARE;
              end else begin
                state_q <= ST_IDLE;
              end
              for (int s = 0; s < LONG_NAME_SLOTS; s++) len_q[s] <= '0;
            end else begin
              step_q <= step_q + 4'd1;
            end
            if (sc != 8'h20) nout_q <= nout_q + 6'd1;
          end
        end
        ST_BARE: begin
          if (fire) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[bench/fdep_checker.sv]
// checker for the fat directory entry parser: predicts results and compares them
`timescale 1ns / 1ps
module fdep_checker
  import fdep_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o
);

  localparam logic [4:0] LfnPos [CharsPerSlot] =
    '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30};

  // predictor state
  logic [7:0]  ent [32];
  logic [4:0]  pos;
  logic [7:0]  lname [LongNameSlots*CharsPerSlot];
  logic [3:0]  llen [LongNameSlots];
  logic [15:0] ent_cnt;
  logic [15:0] rec_cnt;
  logic        dir_done;

  result_t expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v >= CountLimit) ? 16'(CountLimit) : v + 16'd1;
  endfunction

  // turn a complete entry into expected results
  task automatic decode_entry(input logic [15:0] idx);
    logic [7:0]  attr;
    logic [31:0] size, clus;
    logic [7:0]  ch [$];
    logic [1:0]  kd [$];
    logic [7:0]  c;
    int          seq, cnt;
    result_t     r;
    attr = ent[11];
    if (ent[0] == 8'hE5) return;
    if ((attr & 8'h3F) == 8'h0F) begin
      seq = ent[0] & 8'h0F;
      if (seq == 0 || seq > LongNameSlots) return;
      cnt = 0;
      for (int i = 0; i < CharsPerSlot; i++) begin
        c = ent[LfnPos[i]];
        if (c == 8'h00 || c == 8'hFF) break;
        lname[(seq-1)*CharsPerSlot + cnt] = c;
        cnt++;
      end
      llen[seq-1] = 4'(cnt);
      return;
    end
    if ((attr & 8'h18) == 8'h08 && (ent[20] | ent[21] | ent[26] | ent[27]) != 0) return;
    size = {ent[31], ent[30], ent[29], ent[28]};
    clus = (size != 0) ? {ent[21], ent[20], ent[27], ent[26]} : 32'd0;
    for (int s = 0; s < LongNameSlots; s++)
      for (int i = 0; i < llen[s] && i < CharsPerSlot && ch.size() < LongCap; i++) begin
        ch.push_back(lname[s*CharsPerSlot + i]);
        kd.push_back(KIND_LONG);
      end
    for (int i = 0; i < 11; i++) begin
      c = ent[i];
      if (i == 0 && c == 8'h05) c = 8'hE5;
      if (c == 8'h20) continue;
      if (i == 8) begin
        ch.push_back(8'h2E);
        kd.push_back(KIND_SHORT);
      end
      if (c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
      ch.push_back(c);
      kd.push_back(KIND_SHORT);
    end
    rec_cnt = sat_inc(rec_cnt);
    for (int s = 0; s < LongNameSlots; s++) llen[s] = '0;
    if (ch.size() == 0) begin
      ch.push_back(8'h00);
      kd.push_back(KIND_BARE);
    end
    foreach (ch[k]) begin
      r = '{kind: kd[k], name_char: ch[k], first_cluster: clus, file_size: size,
            entry_index: idx, attributes: attr, record_count: rec_cnt,
            last: (k == ch.size() - 1)};
      expected_q.push_back(r);
    end
  endtask

  // one accepted directory byte
  task automatic take_byte(input logic [7:0] b, input logic first);
    logic [15:0] idx;
    result_t     r;
    if (first) begin
      pos = '0;
      for (int s = 0; s < LongNameSlots; s++) llen[s] = '0;
      ent_cnt = '0;
      rec_cnt = '0;
      dir_done = 1'b0;
    end
    if (dir_done) return;
    if (pos == 0 && b == 8'h00) begin
      dir_done = 1'b1;
      r = '{kind: KIND_END, name_char: 8'h00, first_cluster: '0, file_size: '0,
            entry_index: ent_cnt, attributes: 8'h00, record_count: rec_cnt, last: 1'b1};
      expected_q.push_back(r);
      return;
    end
    ent[pos] = b;
    if (pos != 5'd31) begin
      pos++;
      return;
    end
    pos = '0;
    idx = ent_cnt;
    ent_cnt = sat_inc(ent_cnt);
    decode_entry(idx);
  endtask

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      pos = '0;
      for (int s = 0; s < LongNameSlots; s++) llen[s] = '0;
      ent_cnt = '0;
      rec_cnt = '0;
      dir_done = 1'b0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{kind: m_axis_tdata[1:0], name_char: m_axis_tdata[9:2],
                first_cluster: m_axis_tdata[41:10], file_size: m_axis_tdata[73:42],
                entry_index: m_axis_tdata[89:74], attributes: m_axis_tdata[97:90],
                record_count: m_axis_tdata[113:98], last: m_axis_tlast};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_axis_tdata[119:114] !== '0) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tuser);
    end
  end

endmodule

[bench/tb_top.sv]
// top of the fat directory entry parser bench: stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import fdep_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count, pending;
  int           send_idle, recv_stall;
  int           n_sent = 0;
  int           phase_cnt = 0;

  always #5 clk_i = ~clk_i;

  fat_directory_entry_parser_core dut (.*);

  fdep_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at the current rate
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // send one byte, idling beforehand at the current rate
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
  endtask

  // each entry runs under the next idling phase
  task automatic send_entry(input logic [7:0] e [32], input logic first);
    case (phase_cnt % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 59; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 59; end
      default: begin send_idle = 20; recv_stall = 20; end
    endcase
    phase_cnt++;
    for (int i = 0; i < 32; i++) send_byte(e[i], first && i == 0);
  endtask

  // build an entry of a random flavour
  task automatic make_entry(output logic [7:0] e [32], input int flavour);
    for (int i = 0; i < 32; i++) e[i] = 8'($urandom);
    case (flavour)
      0: begin
        e[11] = 8'h0F | (8'($urandom_range(3)) << 6);
        e[0] = 8'($urandom_range(5)) | 8'h40;
        if ($urandom_range(3) == 0) e[2*$urandom_range(12)+1] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      1: begin
        for (int i = 0; i < 11; i++)
          e[i] = ($urandom_range(3) == 0) ? 8'h20 : 8'($urandom_range(8'h30, 8'h7A));
        if ($urandom_range(5) == 0) e[0] = 8'h05;
        e[11] = 8'($urandom_range(8'h3F)) & ~8'h08;
        if ($urandom_range(3) == 0) {e[31], e[30], e[29], e[28]} = '0;
      end
      2: e[0] = 8'hE5;
      3: begin
        e[11] = 8'h08;
        if ($urandom_range(1)) begin
          e[20] = 8'h00; e[21] = 8'h00; e[26] = 8'h00; e[27] = 8'h00;
        end
      end
      default: if (e[0] == 8'h00) e[0] = 8'h01;
    endcase
    if (e[0] == 8'h00) e[0] = 8'h41;
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL fat_directory_entry_parser_core");
    $finish;
  end

  initial begin
    logic [7:0] e [32];
    send_idle = 0;
    recv_stall = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: long names in every slot, short name, blank name, label, free, end
    for (int s = 0; s <= 5; s++) begin
      for (int i = 0; i < 32; i++) e[i] = 8'h41 + 8'(i);
      e[0] = 8'(s); e[11] = 8'h0F;
      if (s == 0) e[0] = 8'h40;
      send_entry(e, s == 0);
    end
    for (int i = 0; i < 32; i++) e[i] = 8'h20;
    e[0] = 8'h05; e[8] = 8'h5A; e[11] = 8'h10; e[28] = 8'hFF; e[31] = 8'hFF;
    e[26] = 8'hFF; e[21] = 8'hFF;
    send_entry(e, 1'b0);
    for (int i = 0; i < 32; i++) e[i] = 8'h20;
    e[11] = 8'h00;
    send_entry(e, 1'b0);
    for (int i = 0; i < 32; i++) e[i] = 8'h00;
    e[0] = 8'h4C; e[11] = 8'h08; e[26] = 8'h01;
    send_entry(e, 1'b0);
    e[0] = 8'hE5;
    send_entry(e, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_quiet();

    // random directories across idling phases
    while (n_sent < 480) begin
      for (int n = $urandom_range(2); n >= 0 && n_sent < 480; n--) begin
        make_entry(e, $urandom_range(5));
        if ($urandom_range(9) == 0) begin
          e[0] = 8'h00;
          for (int i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);
        end
        send_entry(e, n == 2 || $urandom_range(7) == 0);
        if ($urandom_range(9) == 0) send_byte(8'($urandom), 1'b0);
      end
      if ($urandom_range(1)) send_byte(8'h00, 1'b0);
    end
    wait_quiet();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS fat_directory_entry_parser_core");
    end else begin
      $display("FAIL fat_directory_entry_parser_core");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fdep_pkg.sv
rtl/fdep_out_reg.sv
rtl/fat_directory_entry_parser_core.sv
bench/fdep_checker.sv
bench/tb_top.sv
